// ===== rtl/tfd_pkg.sv =====
package tfd_pkg;

   // input commands (req_tuser)
   localparam logic [1:0] CMD_BYTE       = 2'd0;
   localparam logic [1:0] CMD_TICK       = 2'd1;
   localparam logic [1:0] CMD_DIST_RESET = 2'd2;

   // result kinds (rsp_tuser)
   localparam logic [1:0] KIND_SPEED    = 2'd0;
   localparam logic [1:0] KIND_DISTANCE = 2'd1;
   localparam logic [1:0] KIND_BATTERY  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_TIMEOUT     = 2'd0;
   localparam logic [1:0] CSR_SPEED_CONST = 2'd1;
   localparam logic [1:0] CSR_DIST_COEFF  = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   // frame layout
   localparam logic [2:0]  HDR_TYPE_MOTION  = 3'd1;
   localparam logic [2:0]  HDR_TYPE_BATTERY = 3'd2;
   localparam logic [7:0]  ID_SPEED         = 8'h81;
   localparam logic [7:0]  ID_DISTANCE      = 8'h82;
   localparam logic [4:0]  LEN_EXTRA        = 5'd2;
   localparam logic [4:0]  LEN_SPEED        = 5'd5;
   localparam logic [4:0]  LEN_DISTANCE     = 5'd7;
   localparam logic [4:0]  LEN_BATTERY      = 5'd3;
   localparam int          PAYLOAD_DEPTH    = 6;
   localparam logic [15:0] INTERVAL_NONE    = 16'hFFFF;
   localparam logic [31:0] SPEED_SATURATED  = 32'hFFFF_FFFF;

   // millivolts = reading * 4587 / 1024
   localparam logic [12:0] BATT_MV_NUM   = 13'd4587;
   localparam int          BATT_MV_SHIFT = 10;

   localparam int          DIV_STEPS = 32;

   // decode outcome of a finished frame
   localparam logic [2:0] DEC_NONE      = 3'd0;
   localparam logic [2:0] DEC_SPEED_DIV = 3'd1;
   localparam logic [2:0] DEC_SPEED_FIX = 3'd2;
   localparam logic [2:0] DEC_DISTANCE  = 3'd3;
   localparam logic [2:0] DEC_BATTERY   = 3'd4;

   typedef struct packed {
      logic take;
      logic decode;
      logic div_step;
      logic mul;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] dec;
      logic       out_free;
   } dp_status_type;

endpackage

// ===== rtl/tfd_ctrl.sv =====
module tfd_ctrl
   import tfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            count_in   = '0;
            case (status.dec)
               DEC_NONE:      state_in = S_IDLE;
               DEC_SPEED_DIV: state_in = S_DIV;
               DEC_DISTANCE:  state_in = S_MUL;
               default:       state_in = S_EMIT;
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/tfd_dp.sv =====
module tfd_dp
   import tfd_pkg::*;
#(
   parameter int IDLE_COUNTER_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [1:0]    req_command,
   input  logic [7:0]    req_rx_byte,
   input  logic          csr_valid,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_data,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output logic [1:0]    rsp_kind,
   output logic [31:0]   rsp_raw_value,
   output logic [47:0]   rsp_scaled_value,
   output logic          rsp_battery_critical,
   output logic          rsp_interval_zero
);

   localparam int CMP_W = (IDLE_COUNTER_BITS > 16) ? IDLE_COUNTER_BITS : 16;
   localparam int PIDX_W = $clog2(PAYLOAD_DEPTH);

   // configuration
   logic [15:0] timeout_ff;
   logic [31:0] speed_const_ff;
   logic [31:0] dist_coeff_ff;

   // frame assembly
   logic [7:0]                   header_ff, header_in;
   logic [4:0]                   count_ff, count_in;
   logic [6:0]                   check_ff, check_in;
   logic [7:0]                   payload_ff [PAYLOAD_DEPTH];
   logic                         frame_ok_ff, frame_ok_in;
   logic [31:0]                  last_dist_ff;
   logic [31:0]                  origin_ff;
   logic [IDLE_COUNTER_BITS-1:0] idle_ff;

   logic       is_byte, timed_out;
   logic [4:0] count_eff, count_next, take_len;
   logic [6:0] check_next;
   logic [7:0] header_eff;

   // result under construction
   logic [1:0]  res_kind_ff;
   logic [31:0] res_raw_ff;
   logic [47:0] res_scaled_ff;
   logic        res_crit_ff;
   logic        res_zero_ff;
   logic [16:0] rem_ff;
   logic [15:0] divisor_ff;

   // output register
   logic        out_valid_ff;
   logic [1:0]  out_kind_ff;
   logic [31:0] out_raw_ff;
   logic [47:0] out_scaled_ff;
   logic        out_crit_ff;
   logic        out_zero_ff;

   // decode
   logic [2:0]  hdr_type;
   logic [4:0]  frame_len;
   logic [15:0] interval;
   logic [31:0] distance;
   logic [9:0]  reading;
   logic [22:0] batt_prod;
   logic [2:0]  dec;
   logic [16:0] rem_shift;
   logic [63:0] product;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= TIMEOUT_RESET;
         speed_const_ff <= '0;
         dist_coeff_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TIMEOUT:     timeout_ff     <= csr_data[15:0];
            CSR_SPEED_CONST: speed_const_ff <= csr_data;
            CSR_DIST_COEFF:  dist_coeff_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // byte intake: timeout flush, header/payload capture, running check
   assign is_byte   = (req_command == CMD_BYTE);
   assign timed_out = (count_ff != 5'd0) && (CMP_W'(idle_ff) > CMP_W'(timeout_ff));

   always_comb begin
      count_eff   = timed_out ? 5'd0 : count_ff;
      header_eff  = (count_eff == 5'd0) ? req_rx_byte : header_ff;
      check_next  = (timed_out ? 7'd0 : check_ff) ^ req_rx_byte[6:0];
      count_next  = count_eff + 5'd1;
      take_len    = {1'b0, header_eff[3:0]} + LEN_EXTRA;
      header_in   = header_eff;
      count_in    = count_next;
      check_in    = check_next;
      frame_ok_in = 1'b0;
      if (count_next >= take_len) begin
         count_in    = 5'd0;
         check_in    = 7'd0;
         frame_ok_in = (check_next == 7'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= '0;
         count_ff     <= '0;
         check_ff     <= '0;
         frame_ok_ff  <= 1'b0;
         idle_ff      <= '0;
         origin_ff    <= '0;
         last_dist_ff <= '0;
      end else begin
         if (cmd.take) begin
            frame_ok_ff <= is_byte && frame_ok_in;
            case (req_command)
               CMD_BYTE: begin
                  header_ff   <= header_in;
                  count_ff    <= count_in;
                  check_ff    <= check_in;
                  idle_ff     <= '0;
               end
               CMD_TICK: begin
                  if (idle_ff != '1) begin
                     idle_ff <= idle_ff + 1'b1;
                  end
               end
               CMD_DIST_RESET: begin
                  origin_ff <= last_dist_ff;
               end
               default: ;
            endcase
         end
         if (cmd.decode && dec == DEC_DISTANCE) begin
            last_dist_ff <= distance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && is_byte && count_eff != 5'd0
          && count_eff <= 5'(PAYLOAD_DEPTH)) begin
         payload_ff[PIDX_W'(count_eff - 5'd1)] <= req_rx_byte;
      end
   end

   // frame decode from the captured header and payload
   assign hdr_type  = header_ff[6:4];
   assign frame_len = {1'b0, header_ff[3:0]} + LEN_EXTRA;
   assign interval  = {payload_ff[1][1:0], payload_ff[2][6:0], payload_ff[3][6:0]};
   assign distance  = {payload_ff[1][3:0], payload_ff[2][6:0], payload_ff[3][6:0],
                       payload_ff[4][6:0], payload_ff[5][6:0]};
   assign reading   = {payload_ff[0][2:0], payload_ff[1][6:0]};
   assign batt_prod = {13'd0, reading} * {10'd0, BATT_MV_NUM};

   always_comb begin
      dec = DEC_NONE;
      if (frame_ok_ff) begin
         if (hdr_type == HDR_TYPE_MOTION) begin
            if (payload_ff[0] == ID_SPEED && frame_len >= LEN_SPEED) begin
               if (interval == INTERVAL_NONE || interval == 16'd0) begin
                  dec = DEC_SPEED_FIX;
               end else begin
                  dec = DEC_SPEED_DIV;
               end
            end else if (payload_ff[0] == ID_DISTANCE && frame_len >= LEN_DISTANCE) begin
               dec = DEC_DISTANCE;
            end
         end else if (hdr_type == HDR_TYPE_BATTERY && frame_len >= LEN_BATTERY) begin
            dec = DEC_BATTERY;
         end
      end
   end

   // restoring divide: quotient builds up in the low word of res_scaled_ff
   assign rem_shift = {rem_ff[15:0], res_scaled_ff[31]};
   assign product   = {32'd0, res_raw_ff} * {32'd0, dist_coeff_ff};

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         res_crit_ff <= 1'b0;
         res_zero_ff <= 1'b0;
         rem_ff      <= '0;
         divisor_ff  <= interval;
         case (dec)
            DEC_SPEED_FIX: begin
               res_kind_ff <= KIND_SPEED;
               res_raw_ff  <= {16'd0, interval};
               if (interval == 16'd0) begin
                  res_scaled_ff <= {16'd0, SPEED_SATURATED};
                  res_zero_ff   <= 1'b1;
               end else begin
                  res_scaled_ff <= '0;
               end
            end
            DEC_SPEED_DIV: begin
               res_kind_ff   <= KIND_SPEED;
               res_raw_ff    <= {16'd0, interval};
               res_scaled_ff <= {16'd0, speed_const_ff};
            end
            DEC_DISTANCE: begin
               res_kind_ff <= KIND_DISTANCE;
               res_raw_ff  <= distance - origin_ff;
            end
            DEC_BATTERY: begin
               res_kind_ff   <= KIND_BATTERY;
               res_raw_ff    <= {22'd0, reading};
               res_scaled_ff <= {35'd0, batt_prod[22:BATT_MV_SHIFT]};
               res_crit_ff   <= payload_ff[0][6];
            end
            default: ;
         endcase
      end else if (cmd.div_step) begin
         if (rem_shift >= {1'b0, divisor_ff}) begin
            rem_ff                <= rem_shift - {1'b0, divisor_ff};
            res_scaled_ff[31:0]   <= {res_scaled_ff[30:0], 1'b1};
         end else begin
            rem_ff                <= rem_shift;
            res_scaled_ff[31:0]   <= {res_scaled_ff[30:0], 1'b0};
         end
      end else if (cmd.mul) begin
         res_scaled_ff <= product[63:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_kind_ff   <= res_kind_ff;
         out_raw_ff    <= res_raw_ff;
         out_scaled_ff <= res_scaled_ff;
         out_crit_ff   <= res_crit_ff;
         out_zero_ff   <= res_zero_ff;
      end
   end

   assign status.dec      = dec;
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid           = out_valid_ff;
   assign rsp_kind             = out_kind_ff;
   assign rsp_raw_value        = out_raw_ff;
   assign rsp_scaled_value     = out_scaled_ff;
   assign rsp_battery_critical = out_crit_ff;
   assign rsp_interval_zero    = out_zero_ff;

endmodule

// ===== rtl/telemetry_frame_decoder.sv =====
// Telemetry frame decoder.
// req channel: one transfer per command (tuser) - a received serial byte (tdata),
// a millisecond tick or a distance-reset request. Bytes build frames; a frame
// that passes its 7-bit XOR check and is long enough for its type yields one
// result transfer on the rsp channel (kind in tuser, values in tdata).
// csr channel: register writes (timeout, speed constant, distance coefficient),
// always ready; write only while the decoder is idle.
// A command that yields no result passes only the idle and decode states.
// A battery or saturated/no-speed frame goes from decode straight to the output
// register, a distance frame through one 32x32 multiply stage first, and a speed
// frame through the radix-2 divider, which builds the 32-bit quotient bit by bit.
// The output register frees the input side: a new command is accepted while a
// result waits; if rsp_tready stays low the next result holds in the decoder
// and req_tready stays low until the earlier result is taken.
// Reset (synchronous): no frame pending, idle count and distance origin cleared,
// timeout back to 100 ticks, constants cleared, no result pending.
module telemetry_frame_decoder
   import tfd_pkg::*;
#(
   parameter int IDLE_COUNTER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [31:0] raw_value, [79:32] scaled_value,
                                    // [80] battery_critical, [81] interval_zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   logic [1:0]  rsp_kind;
   logic [31:0] rsp_raw_value;
   logic [47:0] rsp_scaled_value;
   logic        rsp_battery_critical;
   logic        rsp_interval_zero;

   tfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tfd_dp #(
      .IDLE_COUNTER_BITS (IDLE_COUNTER_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_command          (req_tuser),
      .req_rx_byte          (req_tdata),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_tready           (rsp_tready),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_kind             (rsp_kind),
      .rsp_raw_value        (rsp_raw_value),
      .rsp_scaled_value     (rsp_scaled_value),
      .rsp_battery_critical (rsp_battery_critical),
      .rsp_interval_zero    (rsp_interval_zero)
   );

   assign csr_ready = 1'b1;
   assign rsp_tuser = rsp_kind;
   assign rsp_tdata = {6'd0, rsp_interval_zero, rsp_battery_critical,
                       rsp_scaled_value, rsp_raw_value};

endmodule

// ===== test/tfd_checker.sv =====
module tfd_checker
   import tfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          outstanding,
   output int          errors
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_BITS = 16;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] raw;
      logic [47:0] scaled;
      logic        crit;
      logic        izero;
   } decoded_type;

   decoded_type decoded_q[$];

   logic [15:0]          timeout_r;
   logic [31:0]          speed_k;
   logic [31:0]          dist_k;
   logic [7:0]           hdr;
   int unsigned          nbytes;
   logic [6:0]           xsum;
   logic [7:0]           body [PAYLOAD_DEPTH];
   logic [31:0]          last_count;
   logic [31:0]          origin;
   logic [IDLE_BITS-1:0] idle;
   int                   fails = 0;

   initial begin
      outstanding = 0;
      errors = 0;
   end

   // body[k] holds frame byte k+1
   function automatic void decode_complete_frame(input int unsigned len);
      decoded_type r;
      logic [15:0] iv;
      logic [31:0] d;
      logic [31:0] delta;
      logic [9:0]  mv;
      r = '0;
      if (hdr[6:4] == HDR_TYPE_MOTION && body[0] == ID_SPEED) begin
         if (len < LEN_SPEED) return;
         iv = {body[1][1:0], body[2][6:0], body[3][6:0]};
         r.kind = KIND_SPEED;
         r.raw = 32'(iv);
         if (iv == INTERVAL_NONE) begin
            r.scaled = '0;
         end else if (iv == 16'd0) begin
            r.scaled = 48'(SPEED_SATURATED);
            r.izero = 1'b1;
         end else begin
            r.scaled = 48'(speed_k / 32'(iv));
         end
         decoded_q.push_back(r);
      end else if (hdr[6:4] == HDR_TYPE_MOTION && body[0] == ID_DISTANCE) begin
         if (len < LEN_DISTANCE) return;
         d = {body[1][3:0], body[2][6:0], body[3][6:0], body[4][6:0], body[5][6:0]};
         last_count = d;
         delta = d - origin;
         r.kind = KIND_DISTANCE;
         r.raw = delta;
         r.scaled = 48'((64'(delta) * 64'(dist_k)) >> 16);
         decoded_q.push_back(r);
      end else if (hdr[6:4] == HDR_TYPE_BATTERY) begin
         if (len < LEN_BATTERY) return;
         mv = {body[0][2:0], body[1][6:0]};
         r.kind = KIND_BATTERY;
         r.raw = 32'(mv);
         r.scaled = 48'((32'(mv) * 32'(BATT_MV_NUM)) >> BATT_MV_SHIFT);
         r.crit = body[0][6];
         decoded_q.push_back(r);
      end
   endfunction

   function automatic void push_rx_byte(input logic [7:0] b);
      int unsigned len;
      // stale partial frame is thrown away before the new byte counts
      if (nbytes != 0 && idle > timeout_r) begin
         nbytes = 0;
         xsum = '0;
      end
      idle = '0;
      if (nbytes == 0) begin
         hdr = b;
      end else if (nbytes <= PAYLOAD_DEPTH) begin
         body[nbytes-1] = b;
      end
      xsum ^= b[6:0];
      nbytes++;
      len = int'(hdr[3:0]) + 2;
      if (nbytes >= len) begin
         nbytes = 0;
         if (xsum == '0) decode_complete_frame(len);
         xsum = '0;
      end
   endfunction

   function automatic void compare_field(input string field, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         fails++;
      end
   endfunction

   function automatic void check_result();
      decoded_type want;
      if (decoded_q.size() == 0) begin
         $error("result transfer with nothing expected: kind %0d raw 0x%0h",
                rsp_tuser, rsp_tdata[31:0]);
         fails++;
         return;
      end
      want = decoded_q.pop_front();
      compare_field("kind", 64'(want.kind), 64'(rsp_tuser));
      compare_field("raw_value", 64'(want.raw), 64'(rsp_tdata[31:0]));
      compare_field("scaled_value", 64'(want.scaled), 64'(rsp_tdata[79:32]));
      compare_field("battery_critical", 64'(want.crit), 64'(rsp_tdata[80]));
      compare_field("interval_zero", 64'(want.izero), 64'(rsp_tdata[81]));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         timeout_r = TIMEOUT_RESET;
         speed_k = '0;
         dist_k = '0;
         hdr = '0;
         nbytes = 0;
         xsum = '0;
         last_count = '0;
         origin = '0;
         idle = '0;
         decoded_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TIMEOUT:     timeout_r = csr_data[15:0];
               CSR_SPEED_CONST: speed_k = csr_data;
               CSR_DIST_COEFF:  dist_k = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               CMD_BYTE:       push_rx_byte(req_tdata);
               CMD_TICK:       if (idle != '1) idle++;
               CMD_DIST_RESET: origin = last_count;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) check_result();
      end
      outstanding <= decoded_q.size();
      errors <= fails;
   end

endmodule

// ===== test/tb.sv =====
module tb;
   import tfd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_NOP = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;
   int          outstanding;
   int          errors;

   int          gap_pct = 0;
   int          stall_pct = 0;
   int          sent = 0;
   logic [15:0] cur_timeout = TIMEOUT_RESET;
   logic [7:0]  frame_q[$];

   telemetry_frame_decoder DUT (.*);

   tfd_checker decode_check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [7:0] rnd8();
      return 8'($urandom);
   endfunction

   task automatic push_command(input logic [1:0] cmd, input logic [7:0] data);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      if (cmd != CMD_NOP) sent++;
   endtask

   task automatic tick(input int n);
      repeat (n) push_command(CMD_TICK, rnd8());
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // registers change only once the decoder has drained
   task automatic configure(input logic [15:0] tmo, input logic [31:0] spd,
                            input logic [31:0] coeff);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (40) @(posedge clock);
      write_reg(CSR_TIMEOUT, 32'(tmo));
      write_reg(CSR_SPEED_CONST, spd);
      write_reg(CSR_DIST_COEFF, coeff);
      csr_valid <= 1'b0;
      cur_timeout = tmo;
   endtask

   // trim or pad to the header's length, then append the XOR check byte
   function automatic void seal_frame();
      logic [6:0] x;
      int         len;
      len = int'(frame_q[0][3:0]) + 2;
      while (frame_q.size() > len - 1) void'(frame_q.pop_back());
      while (frame_q.size() < len - 1) frame_q.push_back(rnd8());
      x = '0;
      foreach (frame_q[i]) x ^= frame_q[i][6:0];
      frame_q.push_back({1'($urandom), x});
   endfunction

   function automatic void speed_frame(input logic [15:0] iv, input logic [3:0] nib);
      frame_q.delete();
      frame_q.push_back({1'($urandom), HDR_TYPE_MOTION, nib});
      frame_q.push_back(ID_SPEED);
      frame_q.push_back({6'($urandom), iv[15:14]});
      frame_q.push_back({1'($urandom), iv[13:7]});
      frame_q.push_back({1'($urandom), iv[6:0]});
      seal_frame();
   endfunction

   function automatic void distance_frame(input logic [31:0] d, input logic [3:0] nib);
      frame_q.delete();
      frame_q.push_back({1'($urandom), HDR_TYPE_MOTION, nib});
      frame_q.push_back(ID_DISTANCE);
      frame_q.push_back({4'($urandom), d[31:28]});
      frame_q.push_back({1'($urandom), d[27:21]});
      frame_q.push_back({1'($urandom), d[20:14]});
      frame_q.push_back({1'($urandom), d[13:7]});
      frame_q.push_back({1'($urandom), d[6:0]});
      seal_frame();
   endfunction

   function automatic void battery_frame(input logic [9:0] m, input logic crit,
                                         input logic [3:0] nib);
      frame_q.delete();
      frame_q.push_back({1'($urandom), HDR_TYPE_BATTERY, nib});
      frame_q.push_back({1'($urandom), crit, 3'($urandom), m[9:7]});
      frame_q.push_back({1'($urandom), m[6:0]});
      seal_frame();
   endfunction

   function automatic logic [15:0] pick_interval();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return INTERVAL_NONE;
         2: return 16'h0001;
         3: return 16'hFFFE;
         4: return 16'($urandom_range(255, 1));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_count();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(4095));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h0001_0000;
         3: return 32'($urandom_range(65535));
         default: return $urandom;
      endcase
   endfunction

   // well-formed frame, mostly at the minimum length
   function automatic void random_good_frame();
      case ($urandom_range(2))
         0: speed_frame(pick_interval(),
                        ($urandom_range(4) == 0) ? 4'($urandom_range(15, 4)) : 4'd3);
         1: distance_frame(pick_count(),
                           ($urandom_range(4) == 0) ? 4'($urandom_range(15, 6)) : 4'd5);
         default: battery_frame(10'($urandom), 1'($urandom),
                                ($urandom_range(4) == 0) ? 4'($urandom_range(15, 2)) : 4'd1);
      endcase
   endfunction

   // ticks between bytes stay within the timeout so the frame survives
   task automatic send_frame(input bit with_ticks);
      foreach (frame_q[i]) begin
         if (with_ticks && i != 0 && $urandom_range(99) < 15)
            tick($urandom_range(0, (cur_timeout < 3) ? int'(cur_timeout) : 3));
         push_command(CMD_BYTE, frame_q[i]);
      end
   endtask

   initial begin
      int pick;
      int cut;
      int next_cfg;
      int phase;
      int idx;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_BYTE;
      csr_valid = 1'b0;
      csr_index = CSR_TIMEOUT;
      csr_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes and the special cases
      configure(16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      battery_frame(10'h3FF, 1'b1, 4'd1);
      send_frame(0);
      speed_frame(16'h0000, 4'd3);
      send_frame(0);
      speed_frame(INTERVAL_NONE, 4'd3);
      send_frame(0);
      distance_frame(32'hFFFF_FFFF, 4'd5);
      send_frame(0);
      push_command(CMD_DIST_RESET, rnd8());
      distance_frame(32'h0000_0000, 4'd5);
      send_frame(0);
      speed_frame(16'h1234, 4'd2);
      send_frame(0);
      push_command(CMD_NOP, 8'hFF);
      // lone header, one tick past a zero timeout, then a fresh frame
      push_command(CMD_BYTE, 8'h23);
      tick(1);
      battery_frame(10'h000, 1'b0, 4'd1);
      send_frame(0);

      // random traffic
      next_cfg = 0;
      phase = 0;
      while (sent < 1050) begin
         if (sent >= next_cfg) begin
            case ($urandom_range(3))
               0: configure(16'd0, pick_word(), pick_word());
               1: configure(TIMEOUT_RESET, pick_word(), pick_word());
               default: configure(16'($urandom_range(30, 1)), pick_word(), pick_word());
            endcase
            gap_pct = (phase == 2) ? 0 : 19;
            stall_pct = (phase == 2) ? 0 : 19;
            phase++;
            next_cfg = sent + 150;
         end
         pick = $urandom_range(99);
         if (pick < 60) begin
            random_good_frame();
            send_frame(1);
         end else if (pick < 67) begin
            // too short for its kind, or an unknown type or id
            case ($urandom_range(3))
               0: speed_frame(pick_interval(), 4'($urandom_range(2)));
               1: distance_frame(pick_count(), 4'($urandom_range(4)));
               2: battery_frame(10'($urandom), 1'($urandom), 4'd0);
               default: begin
                  frame_q.delete();
                  frame_q.push_back(rnd8());
                  repeat (6) frame_q.push_back(rnd8());
                  seal_frame();
               end
            endcase
            send_frame(1);
         end else if (pick < 75) begin
            random_good_frame();
            idx = $urandom_range(frame_q.size() - 1, 1);
            frame_q[idx] ^= 8'(1 << $urandom_range(6));
            send_frame(1);
         end else if (pick < 81) begin
            random_good_frame();
            cut = $urandom_range(frame_q.size() - 1, 1);
            for (int i = 0; i < cut; i++) push_command(CMD_BYTE, frame_q[i]);
            if (cur_timeout <= 40)
               tick(int'(cur_timeout) + 1 + $urandom_range(2));
            else
               tick($urandom_range(3));
            random_good_frame();
            send_frame(1);
         end else if (pick < 87) begin
            push_command(CMD_DIST_RESET, rnd8());
         end else if (pick < 91) begin
            push_command(CMD_NOP, rnd8());
         end else if (pick < 96) begin
            tick($urandom_range(20));
         end else begin
            repeat ($urandom_range(4, 1)) push_command(CMD_BYTE, rnd8());
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
